// ----- rtl/vpos_pkg.sv -----
// Shared types, constants and helper functions for the timed vent positioner.
// No dependencies; every other file imports this package.
package vpos_pkg;

  localparam int unsigned PosW = 3;
  localparam int unsigned CountW = 8;
  localparam int unsigned HoldW = 8;

  localparam logic [PosW-1:0] PosFirst = 3'd1;
  localparam logic [PosW-1:0] PosLast = 3'd6;
  localparam logic [PosW-1:0] PosNone = 3'd0;

  localparam logic signed [CountW-1:0] Mark1 = 8'sd0;
  localparam logic signed [CountW-1:0] Mark2 = 8'sd6;
  localparam logic signed [CountW-1:0] Mark3 = 8'sd12;
  localparam logic signed [CountW-1:0] Mark4 = 8'sd25;
  localparam logic signed [CountW-1:0] Mark5 = 8'sd40;
  localparam logic signed [CountW-1:0] Mark6 = 8'sd55;

  localparam logic signed [CountW:0] CountMax = 9'sd127;
  localparam logic signed [CountW:0] CountMin = -9'sd128;

  localparam logic signed [1:0] DriveFwd = 2'sd1;
  localparam logic signed [1:0] DriveRev = -2'sd1;
  localparam logic signed [1:0] DriveStop = 2'sd0;

  localparam logic [HoldW-1:0] HoldReset = 8'd10;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET_TARGET = 1'b1
  } cmd_t;

  typedef struct packed {
    logic cmd;
    logic [PosW-1:0] target_value;
  } item_t;

  typedef struct packed {
    logic signed [1:0] motor_drive;
    logic [PosW-1:0] position_now;
    logic signed [CountW-1:0] travel_reading;
    logic count_error;
    logic end_holding;
  } result_t;

  typedef struct packed {
    logic signed [CountW-1:0] travel_count;
    logic signed [1:0] move_dir;
    logic signed [1:0] motor_level;
    logic run_active;
    logic [HoldW-1:0] hold_left;
    logic [PosW-1:0] position_reg;
    logic [PosW-1:0] goal_reg;
  } vpos_state_t;

  function automatic logic [PosW-1:0] mark_position(input logic signed [CountW-1:0] count);
    logic [PosW-1:0] pos;
    unique case (count)
      Mark1: pos = 3'd1;
      Mark2: pos = 3'd2;
      Mark3: pos = 3'd3;
      Mark4: pos = 3'd4;
      Mark5: pos = 3'd5;
      Mark6: pos = 3'd6;
      default: pos = PosNone;
    endcase
    return pos;
  endfunction

  function automatic vpos_state_t evaluate_drive(input vpos_state_t st,
                                                 input logic [HoldW-1:0] hold_ticks);
    vpos_state_t r;
    r = st;
    if (st.goal_reg > st.position_reg) begin
      r.motor_level = DriveFwd;
      r.move_dir = DriveFwd;
      r.run_active = 1'b1;
      r.hold_left = '0;
    end else if (st.goal_reg < st.position_reg) begin
      r.motor_level = DriveRev;
      r.move_dir = DriveRev;
      r.run_active = 1'b1;
      r.hold_left = '0;
    end else begin
      r.move_dir = DriveStop;
      r.run_active = 1'b0;
      if ((st.position_reg == PosFirst || st.position_reg == PosLast) &&
          hold_ticks != '0) begin
        r.hold_left = hold_ticks;
      end else begin
        r.motor_level = DriveStop;
        r.hold_left = '0;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/vpos_step.sv -----
// Combinational next-state logic for one tick or set-target transfer.
// Depends on vpos_pkg for the state type, mark table and drive evaluation.
module vpos_step
  import vpos_pkg::*;
(
  input  vpos_state_t      state_cur,
  input  item_t            item,
  input  logic [HoldW-1:0] hold_ticks,
  output vpos_state_t      state_next
);

  vpos_state_t st_hold;
  vpos_state_t st_move;
  vpos_state_t st_set;
  logic signed [CountW:0] sum;
  logic signed [CountW-1:0] count_sat;
  logic [PosW-1:0] mark;
  logic [PosW-1:0] goal_clamped;

  always_comb begin
    st_hold = state_cur;
    if (state_cur.hold_left != '0) begin
      st_hold.hold_left = state_cur.hold_left - 1'b1;
      if (st_hold.hold_left == '0) begin
        st_hold.motor_level = DriveStop;
        st_hold.move_dir = DriveStop;
      end
    end
  end

  always_comb begin
    sum = {st_hold.travel_count[CountW-1], st_hold.travel_count} +
          {{(CountW-1){st_hold.move_dir[1]}}, st_hold.move_dir};
    priority if (sum > CountMax) begin
      count_sat = CountMax[CountW-1:0];
    end else if (sum < CountMin) begin
      count_sat = CountMin[CountW-1:0];
    end else begin
      count_sat = sum[CountW-1:0];
    end
    mark = mark_position(count_sat);
  end

  always_comb begin
    st_move = st_hold;
    if (st_hold.run_active) begin
      st_move.travel_count = count_sat;
      if (mark != PosNone) begin
        st_move.position_reg = mark;
        st_move = evaluate_drive(st_move, hold_ticks);
      end
    end
  end

  always_comb begin
    priority if (item.target_value == '0) begin
      goal_clamped = PosFirst;
    end else if (item.target_value > PosLast) begin
      goal_clamped = PosLast;
    end else begin
      goal_clamped = item.target_value;
    end
    st_set = state_cur;
    st_set.goal_reg = goal_clamped;
    st_set = evaluate_drive(st_set, hold_ticks);
  end

  assign state_next = (item.cmd == CMD_SET_TARGET) ? st_set : st_move;

endmodule

// ----- rtl/timed_vent_positioner.sv -----
// Top level of the timed vent positioner: state registers, result register, handshakes.
// Depends on vpos_pkg and vpos_step.
//
//   Channel  Signals                              Direction
//   item     item_valid, item_ready, item         in
//   result   result_valid, result_ready, result   out
//   config   cfg_wr_en, cfg_wr_data               in
//
// Each transfer writes the state and result registers; its result is valid in the next cycle.
// One item is taken every cycle while the result register is empty or being drained.
// A stalled result holds in the result register and blocks new items until it is taken.
// Synchronous reset restores the default state and hold time and empties the result register.
module timed_vent_positioner
  import vpos_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_wr_en,
  input  logic [HoldW-1:0] cfg_wr_data
);

  vpos_state_t state;
  vpos_state_t state_next;
  logic [HoldW-1:0] end_hold_ticks;
  logic accept;

  assign item_ready = !result_valid || result_ready;
  assign accept = item_valid && item_ready;

  vpos_step u_step (
    .state_cur  (state),
    .item       (item),
    .hold_ticks (end_hold_ticks),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      end_hold_ticks <= HoldReset;
      state.travel_count <= '0;
      state.move_dir <= DriveStop;
      state.motor_level <= DriveStop;
      state.run_active <= 1'b0;
      state.hold_left <= '0;
      state.position_reg <= PosFirst;
      state.goal_reg <= PosFirst;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        end_hold_ticks <= cfg_wr_data;
      end
      if (accept) begin
        state <= state_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.motor_drive <= state_next.motor_level;
      result.position_now <= state_next.position_reg;
      result.travel_reading <= state_next.travel_count;
      result.count_error <= state_next.travel_count[CountW-1];
      result.end_holding <= (state_next.hold_left != '0);
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("Accepted transfer did not produce a result.");

  a_hold_not_moving: assert property (@(posedge clk) disable iff (rst)
    (state.hold_left != '0) |-> !state.run_active)
    else $error("End hold is active while a move runs.");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    (state.position_reg != PosNone) && (state.position_reg != 3'd7) &&
    (state.goal_reg != PosNone) && (state.goal_reg != 3'd7))
    else $error("Position or goal left the range one to six.");

  a_error_matches_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.count_error == result.travel_reading[CountW-1]))
    else $error("Count error flag disagrees with the travel count sign.");

endmodule
